@@ rtl/core/sssrs_pkg.sv @@
// Shared types and codes for the shortest-seek request scheduler.
// No dependencies; included first.
`timescale 1ns / 1ps
package sssrs_pkg;
  localparam int unsigned SectorW = 48;
  localparam int unsigned CountW  = 6;

  typedef enum logic [1:0] {
    ST_ADDED      = 2'd0,
    ST_DISPATCHED = 2'd1,
    ST_EMPTY      = 2'd2,
    ST_FULL       = 2'd3
  } status_t;

  localparam logic MODE_ADD      = 1'b0;
  localparam logic MODE_DISPATCH = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [SectorW-1:0] sector;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [SectorW-1:0] dispatched_sector;
    logic [CountW-1:0]  pending_count;
  } rsp_t;
endpackage

@@ rtl/core/sssrs_cell.sv @@
// One queue slot: holds a sector, shifts down to close a gap.
// Depends on nothing but its parameter.
`timescale 1ns / 1ps
module sssrs_cell #(
  parameter int unsigned SECTOR_BITS = 48
) (
  input  logic                   clk,
  input  logic                   load,
  input  logic                   shift,
  input  logic [SECTOR_BITS-1:0] load_sector,
  input  logic [SECTOR_BITS-1:0] upper_sector,
  output logic [SECTOR_BITS-1:0] sector
);
  always_ff @(posedge clk) begin
    if (load) begin
      sector <= load_sector;
    end else if (shift) begin
      sector <= upper_sector;
    end
  end
endmodule

@@ rtl/core/shortest_seek_request_scheduler_top.sv @@
// Top level: request queue as a row of cells plus a scan/shift sequencer.
// Depends on sssrs_pkg and sssrs_cell.
`timescale 1ns / 1ps
//
//  channel | dir | handshake      | payload
//  --------+-----+----------------+----------------------------
//  req     | in  | req_valid/stall| mode, sector
//  rsp     | out | rsp_valid/stall| status, dispatched_sector,
//          |     |                | pending_count
//
// Add: the result is registered on accept. Dispatch: one slot per
// cycle through a single distance comparator, then the cells from the
// chosen slot up to the last one shift down one at a time. Reset
// clears count, last sector and the control; slot contents need none.
// A stalled result holds and blocks the next transfer on req.
module shortest_seek_request_scheduler_top #(
  parameter int unsigned QUEUE_DEPTH = 32,
  parameter int unsigned SECTOR_BITS = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  sssrs_pkg::req_t    req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output sssrs_pkg::rsp_t    rsp
);
  import sssrs_pkg::*;

  localparam int unsigned IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SHIFT, S_OUT} state_t;

  state_t                 state;
  logic [CntW-1:0]        count;
  logic [SECTOR_BITS-1:0] last_sector;
  logic [IdxW-1:0]        idx;
  logic [IdxW-1:0]        best;
  logic [SECTOR_BITS-1:0] best_d;
  logic [SECTOR_BITS-1:0] best_s;

  logic [SECTOR_BITS-1:0] slot [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] load_v;
  logic [QUEUE_DEPTH-1:0] shift_v;

  logic                   take;
  logic [SECTOR_BITS-1:0] in_sec;
  logic [SECTOR_BITS-1:0] cur;
  logic [SECTOR_BITS-1:0] cur_d;

  assign req_stall = (state != S_IDLE);
  assign take = req_valid && !req_stall;

  // Sector masked to SECTOR_BITS (zero-extend when wider than the field).
  always_comb begin
    in_sec = '0;
    for (int b = 0; b < SECTOR_BITS; b++) begin
      if (b < SectorW) in_sec[b] = req.sector[b];
    end
  end

  assign cur   = slot[idx];
  assign cur_d = (cur > last_sector) ? (cur - last_sector) : (last_sector - cur);

  // Each cell either loads a new tail entry or takes its upper neighbor.
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic [SECTOR_BITS-1:0] up;
    if (g == QUEUE_DEPTH - 1) begin : g_top
      assign up = '0;
    end else begin : g_mid
      assign up = slot[g+1];
    end
    assign load_v[g]  = take && (req.mode == MODE_ADD) &&
                        (count < CntW'(QUEUE_DEPTH)) && (count == CntW'(g));
    assign shift_v[g] = (state == S_SHIFT) && (idx == IdxW'(g));
    sssrs_cell #(.SECTOR_BITS(SECTOR_BITS)) u_cell (
      .clk         (clk),
      .load        (load_v[g]),
      .shift       (shift_v[g]),
      .load_sector (in_sec),
      .upper_sector(up),
      .sector      (slot[g])
    );
  end

  // Result sector narrowed/extended to the 48-bit field.
  function automatic logic [SectorW-1:0] to_out(input logic [SECTOR_BITS-1:0] s);
    logic [SectorW-1:0] r;
    r = '0;
    for (int b = 0; b < SectorW; b++) begin
      if (b < SECTOR_BITS) r[b] = s[b];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      last_sector <= '0;
      rsp_valid   <= 1'b0;
      idx         <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (take) begin
            if (req.mode == MODE_ADD) begin
              rsp.dispatched_sector <= '0;
              if (count >= CntW'(QUEUE_DEPTH)) begin
                rsp.status <= ST_FULL;
                rsp.pending_count <= CountW'(count);
              end else begin
                rsp.status <= ST_ADDED;
                rsp.pending_count <= CountW'(count + 1'b1);
                count <= count + 1'b1;
              end
              rsp_valid <= 1'b1;
              state <= S_OUT;
            end else if (count == '0) begin
              rsp.status <= ST_EMPTY;
              rsp.dispatched_sector <= '0;
              rsp.pending_count <= '0;
              rsp_valid <= 1'b1;
              state <= S_OUT;
            end else begin
              idx    <= '0;
              best   <= '0;
              best_d <= '1;
              state  <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // strict less keeps the oldest on a tie; idx 0 always wins first
          if (idx == '0 || cur_d < best_d) begin
            best_d <= cur_d;
            best   <= idx;
            best_s <= cur;
          end
          if (CntW'(idx) == count - 1'b1) begin
            idx <= (idx == '0 || cur_d < best_d) ? idx : best;
            state <= S_SHIFT;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_SHIFT: begin
          if (CntW'(idx) >= count - 1'b1) begin
            count <= count - 1'b1;
            last_sector <= best_s;
            rsp.status <= ST_DISPATCHED;
            rsp.dispatched_sector <= to_out(best_s);
            rsp.pending_count <= CountW'(count - 1'b1);
            rsp_valid <= 1'b1;
            state <= S_OUT;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_OUT: begin
          if (!rsp_stall) begin
            rsp_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ tb/sv/shortest_seek_request_scheduler_top_tb.sv @@
// Testbench for the shortest-seek request scheduler: random add/dispatch traffic,
// checked transfer by transfer against an in-bench queue predictor.
// Depends on sssrs_pkg and shortest_seek_request_scheduler_top.
`timescale 1ns / 1ps
module shortest_seek_request_scheduler_top_tb;
  import sssrs_pkg::*;

  localparam int unsigned Depth = 32;
  localparam logic [SectorW-1:0] SectorMax = '1;
  localparam int unsigned CycleLimit = 1500000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  shortest_seek_request_scheduler_top dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always #6 clk = ~clk;

  // Predictor state: pending sectors in arrival order, plus the head position.
  logic [SectorW-1:0] pending_q[$];
  logic [SectorW-1:0] head_pos = '0;
  rsp_t expected_rsp_q[$];

  // Items waiting to be driven; the random part fills it as it goes.
  req_t pending_req_q[$];
  int unsigned fail_cnt = 0;
  bit hold_rsp = 1'b0;     // long receiver hold-off request
  int unsigned cycle_cnt = 0;

  // Random part stops after about 1750 items have been queued in total.
  int unsigned queued_total = 0;

  function automatic logic [SectorW-1:0] seek_dist(logic [SectorW-1:0] a,
                                                   logic [SectorW-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic bit rand_count_done();
    return queued_total >= 1750;
  endfunction

  // Apply one accepted item to the predictor and queue its result.
  function automatic void predict_transfer(req_t r);
    rsp_t e;
    int best;
    e = '0;
    if (r.mode == MODE_ADD) begin
      if (pending_q.size() >= Depth) begin
        e.status = ST_FULL;
      end else begin
        pending_q.push_back(r.sector);
        e.status = ST_ADDED;
      end
    end else if (pending_q.size() == 0) begin
      e.status = ST_EMPTY;
    end else begin
      // strict less-than keeps the oldest entry on a tie
      best = 0;
      for (int i = 1; i < pending_q.size(); i++)
        if (seek_dist(pending_q[i], head_pos) < seek_dist(pending_q[best], head_pos))
          best = i;
      e.status = ST_DISPATCHED;
      e.dispatched_sector = pending_q[best];
      head_pos = pending_q[best];
      pending_q.delete(best);
    end
    e.pending_count = CountW'(pending_q.size());
    expected_rsp_q.push_back(e);
  endfunction

  // Driver: one item per transfer, random gap after each.
  int unsigned req_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) begin
        predict_transfer(req);
        void'(pending_req_q.pop_front());
        req_valid <= 1'b0;
        req_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      end else if (req_valid) begin
        // stalled: hold payload
      end else if (req_gap != 0) begin
        req_gap <= req_gap - 1;
      end else if (pending_req_q.size() > 0) begin
        req <= pending_req_q[0];
        req_valid <= 1'b1;
      end
    end
  end

  // Monitor: random stall per transfer, with an optional long hold-off.
  int unsigned rsp_wait = 0;
  always @(posedge clk) begin
    rsp_t e;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, rsp);
          fail_cnt++;
        end else begin
          e = expected_rsp_q.pop_front();
          if (rsp.status !== e.status)
            $display("%0t: status expected %0d got %0d", $time, e.status, rsp.status);
          if (rsp.dispatched_sector !== e.dispatched_sector)
            $display("%0t: sector expected %h got %h", $time,
                     e.dispatched_sector, rsp.dispatched_sector);
          if (rsp.pending_count !== e.pending_count)
            $display("%0t: count expected %0d got %0d", $time,
                     e.pending_count, rsp.pending_count);
          if (rsp !== e) fail_cnt++;
        end
        rsp_wait <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 14);
        rsp_stall <= 1'b1;
      end else if (hold_rsp) begin
        rsp_stall <= 1'b1;
      end else if (rsp_wait != 0) begin
        rsp_wait <= rsp_wait - 1;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here.
  int unsigned hold_left = 0;
  bit hold_go = 1'b0;
  always @(posedge clk) begin
    if (hold_go && hold_left == 0 && !hold_rsp) begin
      hold_left <= 3000;
      hold_rsp <= 1'b1;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
    end else if (hold_left == 1) begin
      hold_left <= 0;
      hold_rsp <= 1'b0;
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Transfer count for the random part.
  always @(posedge clk)
    if (req_valid && !req_stall) queued_total <= queued_total + 1;

  function automatic logic [SectorW-1:0] rand_sector();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return SectorMax;
      2: return SectorW'($urandom_range(0, 63));
      default: return SectorW'({$urandom, $urandom}) & SectorMax;
    endcase
  endfunction

  task automatic push_item(logic m, logic [SectorW-1:0] s);
    req_t r;
    r.mode = m;
    r.sector = s;
    pending_req_q.push_back(r);
  endtask

  task automatic drain();
    while (pending_req_q.size() != 0 || expected_rsp_q.size() != 0 || req_valid)
      @(posedge clk);
  endtask

  initial begin
    logic [SectorW-1:0] base;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty dispatch, extremes, tie (oldest wins), full queue.
    push_item(MODE_DISPATCH, SectorMax);
    push_item(MODE_ADD, SectorMax);
    push_item(MODE_ADD, '0);
    push_item(MODE_DISPATCH, '0);
    push_item(MODE_DISPATCH, '0);
    push_item(MODE_DISPATCH, '0);
    push_item(MODE_ADD, 48'd10);
    push_item(MODE_ADD, 48'd30);
    push_item(MODE_ADD, 48'd20);
    push_item(MODE_ADD, 48'd10);
    push_item(MODE_DISPATCH, '0);
    push_item(MODE_DISPATCH, '0);
    push_item(MODE_DISPATCH, '0);
    push_item(MODE_DISPATCH, '0);
    drain();

    // Fill past full while the receiver holds off; the block must stall req.
    hold_go = 1'b1;
    for (int i = 0; i < Depth + 3; i++) push_item(MODE_ADD, rand_sector());
    wait (hold_rsp);
    hold_go = 1'b0;
    drain();
    for (int i = 0; i < Depth + 1; i++) push_item(MODE_DISPATCH, rand_sector());
    drain();   // sender pause until every result is in

    // Random: bursts of adds and dispatches, clustered sectors for close ties.
    while (!rand_count_done() && cycle_cnt < CycleLimit) begin
      base = rand_sector();
      repeat ($urandom_range(1, 20)) begin
        if ($urandom_range(0, 1))
          push_item(MODE_ADD, $urandom_range(0, 1) ? rand_sector()
                              : (base ^ SectorW'($urandom_range(0, 15))));
        else
          push_item(MODE_DISPATCH, rand_sector());
      end
      while (pending_req_q.size() >= 40) @(posedge clk);
      @(posedge clk);
      if ($urandom_range(0, 40) == 0) drain();
    end
    drain();
    repeat (100) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/core/sssrs_pkg.sv
rtl/core/sssrs_cell.sv
rtl/core/shortest_seek_request_scheduler_top.sv
tb/sv/shortest_seek_request_scheduler_top_tb.sv
